FILE: design/sadu_pkg.sv
`default_nettype none

package sadu_pkg;

   // Program step addresses.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LASTCHK = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SEASON  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MUL_Q   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_COLD    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_S   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ADD     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DECAY   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CLAMP   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_OBS     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_BARE    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd11;

   // Datapath operations.
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_SEASON = 4'd1;
   localparam logic [3:0] OP_MUL_Q  = 4'd2;
   localparam logic [3:0] OP_COLD   = 4'd3;
   localparam logic [3:0] OP_MUL_S  = 4'd4;
   localparam logic [3:0] OP_ADD    = 4'd5;
   localparam logic [3:0] OP_DECAY  = 4'd6;
   localparam logic [3:0] OP_CLAMP  = 4'd7;
   localparam logic [3:0] OP_OBS    = 4'd8;
   localparam logic [3:0] OP_BARE   = 4'd9;
   localparam logic [3:0] OP_EMIT   = 4'd10;

   // Jump conditions; with COND_NEXT the step counter simply advances.
   localparam logic [2:0] COND_NEXT     = 3'd0;
   localparam logic [2:0] COND_ALWAYS   = 3'd1;
   localparam logic [2:0] COND_NO_ITEM  = 3'd2;
   localparam logic [2:0] COND_NOT_LAST = 3'd3;
   localparam logic [2:0] COND_NO_SWE   = 3'd4;
   localparam logic [2:0] COND_OBS      = 3'd5;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BARE   = 3'd0;
   localparam logic [2:0] CSR_FRESH  = 3'd1;
   localparam logic [2:0] CSR_SOUTH  = 3'd2;
   localparam logic [2:0] CSR_OBS    = 3'd3;
   localparam logic [2:0] CSR_WINTER = 3'd4;

   // Register reset values, Q0.16.
   localparam logic [15:0] BARE_RESET  = 16'd11141;
   localparam logic [15:0] FRESH_RESET = 16'd55706;

   // Albedo constants in Q0.16.
   localparam logic [15:0] ALB_065    = 16'd42598;
   localparam logic [15:0] RATE_FAST  = 16'd4653;
   localparam logic [15:0] RATE_MID   = 16'd983;
   localparam logic [15:0] RATE_SLOW  = 16'd66;
   localparam logic [15:0] STEP_YOUNG = 16'd3277;
   localparam logic [15:0] STEP_COLD_DECAY = 16'd393;
   localparam logic [15:0] STEP_BARE_DECAY = 16'd1311;

   localparam logic [23:0] SNOW_MAX = 24'd16777215;

   // The radiation index test Q > 1 compares 522*P - 37100*65536 with
   // 6553600000, where P = R*(65536 - A). Dividing through by 522 gives a
   // limit on P alone; the bound is not a multiple of 522, so P above the
   // limit means Q > 1 and P at or below it means Q < 1.
   localparam logic [47:0] Q_PROD_LIMIT =
      48'((64'd6553600000 + 64'd2431385600) / 64'd522);

   // Reciprocal of 125 scaled by 2**30, rounded up; exact for the
   // 23-bit products that the snow gain step feeds it.
   localparam logic [23:0] SNOW_RECIP = 24'd8589935;
   localparam int RECIP_SHIFT = 30;

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ctl_word_type;

   // Microprogram for one interval.
   function automatic ctl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      unique case (step)
         STEP_WAIT:    w = '{OP_NONE,   COND_NO_ITEM,  STEP_WAIT};
         STEP_LASTCHK: w = '{OP_NONE,   COND_NOT_LAST, STEP_EMIT};
         STEP_SEASON:  w = '{OP_SEASON, COND_NO_SWE,   STEP_BARE};
         STEP_MUL_Q:   w = '{OP_MUL_Q,  COND_NEXT,     STEP_WAIT};
         STEP_COLD:    w = '{OP_COLD,   COND_OBS,      STEP_OBS};
         STEP_MUL_S:   w = '{OP_MUL_S,  COND_NEXT,     STEP_WAIT};
         STEP_ADD:     w = '{OP_ADD,    COND_NEXT,     STEP_WAIT};
         STEP_DECAY:   w = '{OP_DECAY,  COND_NEXT,     STEP_WAIT};
         STEP_CLAMP:   w = '{OP_CLAMP,  COND_ALWAYS,   STEP_EMIT};
         STEP_OBS:     w = '{OP_OBS,    COND_ALWAYS,   STEP_CLAMP};
         STEP_BARE:    w = '{OP_BARE,   COND_ALWAYS,   STEP_EMIT};
         STEP_EMIT:    w = '{OP_EMIT,   COND_ALWAYS,   STEP_WAIT};
         default:      w = '{OP_NONE,   COND_ALWAYS,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: design/snow_albedo_daily_update_unit.sv
// Snow albedo update for one land unit. Each input item is one model
// interval and yields exactly one result item that carries the state after
// that interval. A small microprogram in a read-only table runs the work,
// one step per clock through a shared 24x24 multiplier. An item that is
// not a day's last interval goes from the check step to the emit step; a
// last interval with no snow water runs season, bare and emit; observation
// mode runs season, radiation product, cold, observation, clamp and emit;
// the decay rule runs season, radiation product, cold, snow product, add,
// decay, clamp and emit. The next item is taken at the wait step once the
// result register is free or being read. Configuration writes act at once;
// before the first item they also reset albedo and winter state from the new register values.
`default_nettype none

module snow_albedo_daily_update_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // interval_snow[15:0], day_of_year[24:16], max_temp[38:25],
   // min_temp[52:39], new_snow_today[53], snow_water[73:54],
   // direct_radiation[89:74], observed_albedo[105:90], zero fill above
   input  wire logic [111:0]  req_tdata,
   // first_of_day[0]
   input  wire logic          req_tuser,
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // albedo_out[15:0], winter_out[16], melt_out[17], snow_age_out[25:18],
   // daily_snow_out[49:26], zero fill above
   output logic [55:0]        rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);

   // Sequencer and handshake state.
   logic [sadu_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic init_ff, init_in;

   // Configuration registers.
   logic [15:0] bare_ff, bare_in;
   logic [15:0] fresh_ff, fresh_in;
   logic south_ff, south_in;
   logic obsmode_ff, obsmode_in;
   logic siw_ff, siw_in;

   // Unit state.
   logic [15:0] albedo_ff, albedo_in;
   logic winter_ff, winter_in;
   logic melt_ff, melt_in;
   logic [7:0] age_ff, age_in;
   logic [23:0] daily_ff, daily_in;

   // Latched item fields and work registers.
   logic last_ff;
   logic [8:0] day_ff;
   logic signed [13:0] tmax_ff, tmin_ff;
   logic newsnow_ff;
   logic [19:0] swe_ff;
   logic [15:0] rad_ff, obs_ff;
   logic [47:0] prod_ff, prod_in;
   logic [15:0] a_ff, a_in;
   logic [15:0] rate_ff, rate_in;
   logic mtest_ff, mtest_in;

   sadu_pkg::ctl_word_type ctl;
   logic item_accept;
   logic jump;
   logic [24:0] snow_sum;
   logic [23:0] mul_a, mul_b;
   logic season, q_gt, melt_test;
   logic signed [19:0] tmax_w, tmax_x10, mt_lim;
   logic [15:0] snow_gain;
   logic [16:0] gain_sum;
   logic [15:0] decay;

   assign ctl = sadu_pkg::ucode_rom(pc_ff);
   assign req_tready = (pc_ff == sadu_pkg::STEP_WAIT) && (!rsp_valid_ff || rsp_tready);
   assign item_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, daily_ff, age_ff, melt_ff, winter_ff, albedo_ff};

   // Step counter: jump on the selected condition, else advance.
   always_comb begin
      unique case (ctl.cond)
         sadu_pkg::COND_NEXT:     jump = 1'b0;
         sadu_pkg::COND_ALWAYS:   jump = 1'b1;
         sadu_pkg::COND_NO_ITEM:  jump = !item_accept;
         sadu_pkg::COND_NOT_LAST: jump = !last_ff;
         sadu_pkg::COND_NO_SWE:   jump = (swe_ff == 20'd0);
         sadu_pkg::COND_OBS:      jump = obsmode_ff;
         default:                 jump = 1'b1;
      endcase
      pc_in = jump ? ctl.target : pc_ff + 1'b1;
   end

   // Shared multiplier operands.
   always_comb begin
      if (ctl.op == sadu_pkg::OP_MUL_S) begin
         mul_a = {1'b0, daily_ff[8:0], 14'd0};
         mul_b = sadu_pkg::SNOW_RECIP;
      end else begin
         mul_a = {8'd0, rad_ff};
         mul_b = {7'd0, 17'(17'h10000 - {1'b0, albedo_ff})};
      end
      prod_in = 48'(mul_a) * 48'(mul_b);
   end

   // Seasonal window, melt test and snow gain terms.
   always_comb begin
      season = south_ff ? (day_ff >= 9'd118 && day_ff <= 9'd184)
                        : (day_ff > 9'd300 || day_ff < 9'd2);
      q_gt = prod_ff > sadu_pkg::Q_PROD_LIMIT;
      tmax_w = 20'(tmax_ff);
      tmax_x10 = (tmax_w <<< 3) + (tmax_w <<< 1);
      mt_lim = 20'sd6690 - $signed({5'd0, day_ff, 6'd0});
      // The index is never below -0.5 since P is never negative, so the
      // third clause needs only the temperature compare.
      melt_test = (tmin_ff > -14'sd400) || (q_gt && tmax_ff > 14'sd0) ||
                  (tmax_x10 > mt_lim);
      // Gains of 1.0 or more always hit the fresh-snow cap.
      snow_gain = prod_ff[sadu_pkg::RECIP_SHIFT+15:sadu_pkg::RECIP_SHIFT];
      gain_sum = {1'b0, a_ff} + {1'b0, snow_gain};
   end

   // Decay step chosen by regime, snow age and melt test.
   always_comb begin
      if (!winter_ff) begin
         decay = sadu_pkg::STEP_BARE_DECAY;
      end else if (age_ff < 8'd3) begin
         decay = sadu_pkg::STEP_YOUNG;
      end else if (mtest_ff) begin
         decay = rate_ff;
      end else if (a_ff > sadu_pkg::ALB_065) begin
         decay = sadu_pkg::STEP_COLD_DECAY;
      end else begin
         decay = 16'd0;
      end
   end

   // Configuration writes.
   always_comb begin
      bare_in = bare_ff;
      fresh_in = fresh_ff;
      south_in = south_ff;
      obsmode_in = obsmode_ff;
      siw_in = siw_ff;
      if (csr_we) begin
         unique case (csr_index)
            sadu_pkg::CSR_BARE:   bare_in = csr_wdata;
            sadu_pkg::CSR_FRESH:  fresh_in = csr_wdata;
            sadu_pkg::CSR_SOUTH:  south_in = csr_wdata[0];
            sadu_pkg::CSR_OBS:    obsmode_in = csr_wdata[0];
            sadu_pkg::CSR_WINTER: siw_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Datapath operations under the control word.
   always_comb begin
      albedo_in = albedo_ff;
      winter_in = winter_ff;
      melt_in = melt_ff;
      age_in = age_ff;
      daily_in = daily_ff;
      a_in = a_ff;
      rate_in = rate_ff;
      mtest_in = mtest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      init_in = init_ff;
      snow_sum = {1'b0, daily_ff} + {9'd0, req_tdata[15:0]};

      // Before the first item, a register write re-derives the start state.
      if (init_ff && csr_we) begin
         albedo_in = siw_in ? fresh_in : bare_in;
         winter_in = siw_in;
      end

      // The daily snowfall total moves as the item is taken.
      if (item_accept) begin
         init_in = 1'b0;
         if (req_tuser) begin
            daily_in = {8'd0, req_tdata[15:0]};
         end else if (snow_sum[24]) begin
            daily_in = sadu_pkg::SNOW_MAX;
         end else begin
            daily_in = snow_sum[23:0];
         end
      end

      unique case (ctl.op)
         sadu_pkg::OP_SEASON: begin
            if (season && swe_ff > 20'd500) begin
               winter_in = 1'b1;
               albedo_in = fresh_ff;
            end
            melt_in = 1'b0;
            if (newsnow_ff) begin
               age_in = 8'd0;
            end else if (age_ff != 8'd255) begin
               age_in = age_ff + 8'd1;
            end
         end
         sadu_pkg::OP_COLD: begin
            mtest_in = melt_test;
            if (tmax_ff < -14'sd600 && !q_gt) begin
               winter_in = 1'b1;
               if (melt_test) begin
                  melt_in = 1'b1;
               end
            end
         end
         sadu_pkg::OP_MUL_S: begin
            a_in = albedo_ff;
         end
         sadu_pkg::OP_ADD: begin
            if (swe_ff > 20'd6000) begin
               rate_in = (a_ff > sadu_pkg::ALB_065) ? sadu_pkg::RATE_MID
                                                    : sadu_pkg::RATE_SLOW;
            end else begin
               rate_in = sadu_pkg::RATE_FAST;
            end
            if (daily_ff > 24'd25) begin
               if (daily_ff >= 24'd500 || gain_sum > {1'b0, fresh_ff}) begin
                  a_in = fresh_ff;
               end else begin
                  a_in = gain_sum[15:0];
               end
            end
         end
         sadu_pkg::OP_DECAY: begin
            albedo_in = (a_ff >= decay) ? a_ff - decay : 16'd0;
         end
         sadu_pkg::OP_CLAMP: begin
            if (!winter_ff) begin
               if (albedo_ff < bare_ff) begin
                  albedo_in = bare_ff;
               end
               melt_in = 1'b1;
            end
         end
         sadu_pkg::OP_OBS: begin
            albedo_in = obs_ff;
         end
         sadu_pkg::OP_BARE: begin
            albedo_in = bare_ff;
            winter_in = 1'b0;
            melt_in = 1'b0;
         end
         sadu_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Control, configuration and unit state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sadu_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         init_ff <= 1'b1;
         bare_ff <= sadu_pkg::BARE_RESET;
         fresh_ff <= sadu_pkg::FRESH_RESET;
         south_ff <= 1'b0;
         obsmode_ff <= 1'b0;
         siw_ff <= 1'b0;
         albedo_ff <= sadu_pkg::BARE_RESET;
         winter_ff <= 1'b0;
         melt_ff <= 1'b0;
         age_ff <= 8'd0;
         daily_ff <= 24'd0;
      end else begin
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff <= init_in;
         bare_ff <= bare_in;
         fresh_ff <= fresh_in;
         south_ff <= south_in;
         obsmode_ff <= obsmode_in;
         siw_ff <= siw_in;
         albedo_ff <= albedo_in;
         winter_ff <= winter_in;
         melt_ff <= melt_in;
         age_ff <= age_in;
         daily_ff <= daily_in;
      end
   end

   // Item fields and work registers.
   always_ff @(posedge clock) begin
      if (item_accept) begin
         last_ff <= req_tlast;
         day_ff <= req_tdata[24:16];
         tmax_ff <= req_tdata[38:25];
         tmin_ff <= req_tdata[52:39];
         newsnow_ff <= req_tdata[53];
         swe_ff <= req_tdata[73:54];
         rad_ff <= req_tdata[89:74];
         obs_ff <= req_tdata[105:90];
      end
      if (ctl.op == sadu_pkg::OP_MUL_Q || ctl.op == sadu_pkg::OP_MUL_S) begin
         prod_ff <= prod_in;
      end
      a_ff <= a_in;
      rate_ff <= rate_in;
      mtest_ff <= mtest_in;
   end

   // A result never appears in the cycle right after an item is taken.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      item_accept |=> !rsp_tvalid)
      else $error("result raised directly after item acceptance");

   // A result is raised only by the emit step of the program.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pc_ff) == sadu_pkg::STEP_EMIT)
      else $error("result raised outside the emit step");

   // The unit state (albedo, age, winter, melt) holds while a result waits to be taken.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |=> $stable(albedo_ff) && $stable(age_ff) && $stable(winter_ff)
                     && $stable(melt_ff))
      else $error("unit state changed while a result was pending");

endmodule

`default_nettype wire

FILE: sim/snow_albedo_daily_update_unit_tb.sv
`default_nettype none

module snow_albedo_daily_update_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Constants of the albedo rules; the albedo and decay values are Q0.16.
   localparam longint FULL_SCALE  = 65536;
   localparam longint THRESH_065  = 42598;
   localparam longint DECAY_FAST  = 4653;
   localparam longint DECAY_MID   = 983;
   localparam longint DECAY_SLOW  = 66;
   localparam longint DROP_YOUNG  = 3277;
   localparam longint DROP_COLD   = 393;
   localparam longint DROP_BARE   = 1311;
   localparam longint SNOW_LIMIT  = 16777215;
   localparam longint AGE_LIMIT   = 255;
   // Radiation index of 1.0 in the scaled integer form.
   localparam longint Q_ONE       = 64'd6553600000;

   // One input item; packed so that a random vector fills every field.
   typedef struct packed {
      logic        first;
      logic        last;
      logic [15:0] obs;
      logic [15:0] rad;
      logic [19:0] swe;
      logic        newsnow;
      logic [13:0] tmin;
      logic [13:0] tmax;
      logic [8:0]  day;
      logic [15:0] isnow;
   } interval_type;

   // One result item, in the bit order of rsp_tdata.
   typedef struct packed {
      logic [23:0] daily;
      logic [7:0]  age;
      logic        melt;
      logic        winter;
      logic [15:0] albedo;
   } albedo_result_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [55:0]   rsp_tdata;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   snow_albedo_daily_update_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Register copies and land unit state of the predictor.
   longint cfg_bare = sadu_pkg::BARE_RESET;
   longint cfg_fresh = sadu_pkg::FRESH_RESET;
   bit     cfg_south = 1'b0;
   bit     cfg_obs = 1'b0;
   bit     cfg_start = 1'b0;
   longint alb_st = sadu_pkg::BARE_RESET;
   bit     winter_st = 1'b0;
   bit     melt_st = 1'b0;
   longint age_st = 0;
   longint daily_st = 0;
   bit     awaiting_first = 1'b1;

   albedo_result_type pending_albedo_results[$];
   int unsigned    mismatches = 0;
   int unsigned    items_sent = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    cal_day = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the predicted state by one interval and return the result item.
   task automatic update_albedo_model(input interval_type it, output albedo_result_type res);
      longint day, tmax, tmin, swe, rad, q, a, rate, total;
      bit season, melt_test;
      day = it.day;
      tmax = $signed(it.tmax);
      tmin = $signed(it.tmin);
      swe = it.swe;
      rad = it.rad;
      awaiting_first = 1'b0;

      if (it.first) begin
         daily_st = it.isnow;
      end else begin
         total = daily_st + it.isnow;
         daily_st = (total > SNOW_LIMIT) ? SNOW_LIMIT : total;
      end

      if (it.last) begin
         season = cfg_south ? (day >= 118 && day <= 184) : (day > 300 || day < 2);
         if (season && swe > 500) begin
            winter_st = 1'b1;
            alb_st = cfg_fresh;
         end
         melt_st = 1'b0;
         if (it.newsnow) begin
            age_st = 0;
         end else if (age_st < AGE_LIMIT) begin
            age_st++;
         end

         if (swe == 0) begin
            alb_st = cfg_bare;
            winter_st = 1'b0;
            melt_st = 1'b0;
         end else begin
            q = -37100 * FULL_SCALE + 522 * rad * (FULL_SCALE - alb_st);
            melt_test = (tmin > -400) || (q > Q_ONE && tmax > 0) ||
                        (10 * tmax > 6690 - 64 * day && q > -(Q_ONE / 2));
            if (tmax < -600 && q < Q_ONE) begin
               winter_st = 1'b1;
               if (melt_test) melt_st = 1'b1;
            end

            if (cfg_obs) begin
               alb_st = it.obs;
            end else begin
               a = alb_st;
               rate = DECAY_FAST;
               if (swe > 6000) rate = (a > THRESH_065) ? DECAY_MID : DECAY_SLOW;
               // Fresh snow of the day brightens the surface, up to fresh snow.
               if (daily_st > 25) begin
                  a += (daily_st * 131072) / 1000;
                  if (a > cfg_fresh) a = cfg_fresh;
               end
               if (winter_st) begin
                  if (age_st < 3) a -= DROP_YOUNG;
                  else if (melt_test) a -= rate;
                  else if (a > THRESH_065) a -= DROP_COLD;
               end else begin
                  a -= DROP_BARE;
               end
               alb_st = (a < 0) ? 0 : a;
            end

            if (!winter_st) begin
               if (alb_st < cfg_bare) alb_st = cfg_bare;
               melt_st = 1'b1;
            end
         end
      end

      res.albedo = 16'(alb_st);
      res.winter = winter_st;
      res.melt = melt_st;
      res.age = 8'(age_st);
      res.daily = 24'(daily_st);
   endtask

   // Write one register while the block is idle and mirror it in the predictor.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      bit known;
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      known = 1'b1;
      case (idx)
         sadu_pkg::CSR_BARE:   cfg_bare = data;
         sadu_pkg::CSR_FRESH:  cfg_fresh = data;
         sadu_pkg::CSR_SOUTH:  cfg_south = data[0];
         sadu_pkg::CSR_OBS:    cfg_obs = data[0];
         sadu_pkg::CSR_WINTER: cfg_start = data[0];
         default:              known = 1'b0;
      endcase
      // Before the first interval the initial albedo follows the registers.
      if (known && awaiting_first) begin
         alb_st = cfg_start ? cfg_fresh : cfg_bare;
         winter_st = cfg_start;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] bare, input logic [15:0] fresh,
                             input logic [15:0] south, input logic [15:0] obs,
                             input logic [15:0] start);
      write_reg(sadu_pkg::CSR_BARE, bare);
      write_reg(sadu_pkg::CSR_FRESH, fresh);
      write_reg(sadu_pkg::CSR_SOUTH, south);
      write_reg(sadu_pkg::CSR_OBS, obs);
      write_reg(sadu_pkg::CSR_WINTER, start);
   endtask

   // Offer one item, with random idle cycles first, and record its predicted result.
   task automatic send_interval(input interval_type it);
      albedo_result_type res;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.first;
      req_tlast <= it.last;
      req_tdata <= {6'b0, it.obs, it.rad, it.swe, it.newsnow, it.tmin, it.tmax,
                    it.day, it.isnow};
      do @(posedge clock); while (!req_tready);
      update_albedo_model(it, res);
      pending_albedo_results.push_back(res);
      items_sent++;
   endtask

   // Hold the sender until every expected result has arrived.
   task automatic wait_results_done();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_albedo_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic interval_type mk(input bit first, input bit last, input int isnow,
                                       input int day, input int tmax, input int tmin,
                                       input bit newsnow, input int swe, input int rad,
                                       input int obs);
      interval_type it;
      it.first = first;
      it.last = last;
      it.isnow = 16'(isnow);
      it.day = 9'(day);
      it.tmax = 14'(tmax);
      it.tmin = 14'(tmin);
      it.newsnow = newsnow;
      it.swe = 20'(swe);
      it.rad = 16'(rad);
      it.obs = 16'(obs);
      return it;
   endfunction

   function automatic interval_type rand_noise();
      logic [127:0] r;
      r = {$urandom(), $urandom(), $urandom(), $urandom()};
      return interval_type'(r[107:0]);
   endfunction

   // One well-formed day of n intervals with random weather for the day.
   task automatic send_random_day(input int n, input int newsnow_pct, input bit heavy);
      interval_type it;
      int t;
      it = rand_noise();
      cal_day = cal_day % 366 + 1;
      it.day = 9'(cal_day);
      if ($urandom_range(49) == 0) it.day = 9'($urandom_range(511));
      t = $urandom_range(9);
      if (t < 5) t = int'($urandom_range(2399)) - 3000;
      else if (t < 9) t = int'($urandom_range(12000)) - 6000;
      else t = $urandom();
      it.tmax = t[13:0];
      t = $urandom_range(9);
      if (t < 5) t = int'($urandom_range(800)) - 800;
      else if (t < 9) t = int'($urandom_range(12000)) - 6000;
      else t = $urandom();
      it.tmin = t[13:0];
      case ($urandom_range(9))
         0:       it.swe = '0;
         1, 2:    it.swe = 20'($urandom_range(500, 1));
         3, 4, 5: it.swe = 20'($urandom_range(6000, 501));
         6, 7, 8: it.swe = 20'($urandom_range(100000, 6001));
         default: it.swe = 20'($urandom());
      endcase
      case ($urandom_range(4))
         0, 1:    it.rad = 16'($urandom_range(300));
         2:       it.rad = 16'($urandom_range(3000));
         default: it.rad = 16'($urandom());
      endcase
      it.newsnow = ($urandom_range(99) < newsnow_pct);
      for (int k = 0; k < n; k++) begin
         it.first = (k == 0);
         it.last = (k == n - 1);
         case (heavy ? 3 : $urandom_range(3))
            0, 1:    it.isnow = '0;
            2:       it.isnow = 16'($urandom_range(50));
            default: it.isnow = heavy ? 16'($urandom_range(65535, 60000)) : 16'($urandom());
         endcase
         send_interval(it);
      end
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
         default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
   endtask

   // Registers written before any interval set the initial albedo; later ones do not.
   task automatic test_early_config();
      write_reg(sadu_pkg::CSR_BARE, 16'd1000);
      write_reg(sadu_pkg::CSR_FRESH, 16'd60000);
      write_reg(sadu_pkg::CSR_WINTER, 16'd1);
      for (int k = 1; k <= 3; k++) write_reg(3'(sadu_pkg::CSR_WINTER + k), 16'hFFFF);
      send_interval(mk(1, 0, 65535, 10, 500, -500, 0, 2000, 1000, 0));
      wait_results_done();
      write_reg(sadu_pkg::CSR_WINTER, 16'd0);
      write_reg(sadu_pkg::CSR_BARE, sadu_pkg::BARE_RESET);
      write_reg(sadu_pkg::CSR_FRESH, sadu_pkg::FRESH_RESET);
      send_interval(mk(0, 1, 1, 20, 500, -500, 0, 2000, 1000, 0));
   endtask

   // Both day marks on one item, and a day with no snow water.
   task automatic test_day_marks();
      send_interval(mk(1, 1, 30, 40, -1000, -1000, 1, 3000, 0, 0));
      send_interval(mk(1, 0, 100, 41, 200, -200, 0, 0, 500, 0));
      send_interval(mk(0, 1, 0, 41, 200, -200, 0, 0, 500, 0));
   endtask

   // Edges of both winter windows and days outside 1..366.
   task automatic test_season_windows();
      send_interval(mk(1, 1, 0, 301, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 300, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 1, 1000, 1000, 0, 500, 3000, 0));
      send_interval(mk(1, 1, 0, 2, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 0, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 511, -8192, -8192, 0, 501, 0, 0));
      wait_results_done();
      write_reg(sadu_pkg::CSR_SOUTH, 16'd1);
      send_interval(mk(1, 1, 0, 118, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 184, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 117, 1000, 1000, 0, 501, 3000, 0));
      send_interval(mk(1, 1, 0, 185, 1000, 1000, 0, 501, 3000, 0));
      wait_results_done();
      write_reg(sadu_pkg::CSR_SOUTH, 16'd0);
   endtask

   // Cold days with and without melt, temperature and radiation extremes.
   task automatic test_cold_and_melt();
      send_interval(mk(1, 1, 0, 30, -601, -399, 0, 1000, 0, 0));
      send_interval(mk(1, 1, 0, 31, -8192, -8192, 0, 1000, 0, 0));
      send_interval(mk(1, 1, 0, 32, -8192, -8192, 0, 1048575, 0, 0));
      send_interval(mk(1, 1, 0, 33, -5000, -6000, 0, 6001, 100, 0));
      send_interval(mk(1, 1, 0, 34, 8191, 8191, 0, 6001, 65535, 65535));
   endtask

   // Albedo floor at zero, then the register extremes the other way round.
   task automatic test_albedo_limits();
      wait_results_done();
      write_reg(sadu_pkg::CSR_BARE, 16'd0);
      write_reg(sadu_pkg::CSR_FRESH, 16'd0);
      send_interval(mk(1, 1, 0, 350, -1000, -1000, 1, 1000, 0, 0));
      send_interval(mk(1, 1, 0, 60, 1000, 1000, 0, 1000, 0, 0));
      wait_results_done();
      write_reg(sadu_pkg::CSR_BARE, 16'd65535);
      write_reg(sadu_pkg::CSR_FRESH, 16'd65535);
      send_interval(mk(1, 1, 65535, 351, -1000, -1000, 1, 1000, 0, 0));
   endtask

   // Observation mode takes the observed albedo, with the bare-ground floor outside winter.
   task automatic test_observation();
      wait_results_done();
      set_config(sadu_pkg::BARE_RESET, sadu_pkg::FRESH_RESET, 16'd0, 16'd1, 16'd0);
      send_interval(mk(1, 1, 0, 70, -1000, -1000, 0, 2000, 0, 0));
      send_interval(mk(1, 1, 0, 71, 1000, 1000, 0, 2000, 3000, 65535));
      send_interval(mk(1, 1, 0, 72, -3000, -3000, 0, 2000, 0, 65535));
      wait_results_done();
      write_reg(sadu_pkg::CSR_OBS, 16'd0);
   endtask

   // Random days and noise under several settings and idling patterns.
   task automatic test_random_phases();
      int unsigned start;
      for (int p = 0; p < 8; p++) begin
         wait_results_done();
         case (p)
            0: set_config(sadu_pkg::BARE_RESET, sadu_pkg::FRESH_RESET, 16'd0, 16'd0, 16'd0);
            1: set_config(16'd0, 16'd65535, 16'd0, 16'd0, 16'd1);
            2: set_config(16'd65535, 16'd0, 16'd1, 16'd0, 16'd0);
            3: set_config(16'($urandom_range(20000)), 16'($urandom_range(65535, 40000)),
                          16'd1, 16'd0, 16'($urandom()));
            4: set_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'hFFFF, 16'($urandom()));
            6: set_config(sadu_pkg::BARE_RESET, sadu_pkg::FRESH_RESET, 16'hFFFE, 16'hFFFE,
                          16'hFFFE);
            default: set_config(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                16'($urandom()), 16'($urandom()));
         endcase
         set_idling(p % 4);
         if (p == 6) begin
            // One very long day overflows the daily total; a dry spell ages the snow.
            send_random_day(300, 0, 1'b1);
            for (int d = 0; d < 280; d++) send_random_day(1, 0, 1'b0);
         end else begin
            start = items_sent;
            while (items_sent - start < 170) begin
               if ($urandom_range(99) < 15) send_interval(rand_noise());
               else send_random_day($urandom_range(6, 1), 40, 1'b0);
            end
         end
      end
      set_idling(0);
   endtask

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s: expected %0d, got %0d", what, want, got);
      end
   endtask

   // Compare every accepted result item with the oldest prediction.
   always @(posedge clock) begin
      albedo_result_type got_res, want_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_res = albedo_result_type'(rsp_tdata[49:0]);
         if (pending_albedo_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result item with no prediction waiting: tdata %h", rsp_tdata);
         end else begin
            want_res = pending_albedo_results.pop_front();
            check_field("albedo_out", want_res.albedo, got_res.albedo);
            check_field("winter_out", want_res.winter, got_res.winter);
            check_field("melt_out", want_res.melt, got_res.melt);
            check_field("snow_age_out", want_res.age, got_res.age);
            check_field("daily_snow_out", want_res.daily, got_res.daily);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_early_config();
      test_day_marks();
      test_season_windows();
      test_cold_and_melt();
      test_albedo_limits();
      test_observation();
      test_random_phases();
      wait_results_done();
      if (mismatches == 0 && pending_albedo_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
design/sadu_pkg.sv
design/snow_albedo_daily_update_unit.sv
sim/snow_albedo_daily_update_unit_tb.sv
